// File: rtl/core/urxf_pkg.sv
// Package for the UART receive FIFO with RTS flow control.
// Holds function codes, register indexes, reset values and the controller types.
// No dependencies.
`timescale 1ns / 1ps

package urxf_pkg;

   // Function codes carried by an input word.
   localparam logic [1:0] FUNC_RECEIVE = 2'd0;
   localparam logic [1:0] FUNC_POP     = 2'd1;
   localparam logic [1:0] FUNC_ENABLE  = 2'd2;
   localparam logic [1:0] FUNC_DISABLE = 2'd3;

   // Configuration register indexes.
   localparam int          CSR_INDEX_W          = 3;
   localparam int          CSR_DATA_W           = 8;
   localparam logic [2:0]  CSR_RTS_USED         = 3'd0;
   localparam logic [2:0]  CSR_PARITY_ENABLED   = 3'd1;
   localparam logic [2:0]  CSR_RTS_OFF_THRESH   = 3'd2;
   localparam logic [2:0]  CSR_RTS_ON_THRESH    = 3'd3;
   localparam logic [2:0]  CSR_ERROR_MARKER     = 3'd4;

   // Field widths fixed by the register map.
   localparam int          THRESH_W  = 6;
   localparam int          BYTE_W    = 8;
   localparam int          ERR_W     = 4;

   // Configuration reset values.
   localparam logic               RST_RTS_USED       = 1'b1;
   localparam logic               RST_PARITY_ENABLED = 1'b0;
   localparam logic [THRESH_W-1:0] RST_RTS_OFF_THRESH = 6'd8;
   localparam logic [THRESH_W-1:0] RST_RTS_ON_THRESH  = 6'd24;
   localparam logic [BYTE_W-1:0]   RST_ERROR_MARKER   = 8'hFF;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // A word is taken this cycle.
      logic load_data;  // Capture the byte read from the store.
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_hit;    // The offered word is a pop that returns a byte.
   } ctrl_status_type;

endpackage

// File: rtl/core/uart_rx_fifo_rts_flow_control.sv
// Channel  | Direction | Handshake             | Contents
// req      | in        | req_valid / req_ready | function code and receive event fields
// rsp      | out       | rsp_valid / rsp_ready | pop byte, status, count, RTS, errors
// csr      | in        | csr_we                | register index and write data
//
// Receive, enable and disable words, and pops that return no byte, register their
// result at the accepting edge. A pop that returns a byte is read through the
// registered read port of the byte store into the result register in ST_READ,
// which holds the input off. Synchronous reset loads the register defaults and
// empties the FIFO at once; there is no clearing pass. A stalled result holds in
// the output register; a word is taken once it empties or drains.
// Top level of the UART receive FIFO with RTS flow control.
// Depends on urxf_pkg, urxf_ctrl and urxf_dp.
`timescale 1ns / 1ps

module uart_rx_fifo_rts_flow_control import urxf_pkg::*; #(
   parameter int FIFO_DEPTH = 32,
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic                   req_rx_byte_ready,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic                   req_parity_fault,
   input  logic                   req_frame_fault,
   input  logic                   req_noise_fault,
   input  logic                   req_overrun_fault,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_read_data,
   output logic                   rsp_read_valid,
   output logic                   rsp_read_error,
   output logic                   rsp_fifo_empty,
   output logic [CNT_W-1:0]       rsp_fifo_count,
   output logic                   rsp_rts_level,
   output logic [ERR_W-1:0]       rsp_error_bits
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Handshake and sequencing.
   urxf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // FIFO state, configuration and result register.
   urxf_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_func          (req_func),
      .req_rx_byte_ready (req_rx_byte_ready),
      .req_rx_byte       (req_rx_byte),
      .req_parity_fault  (req_parity_fault),
      .req_frame_fault   (req_frame_fault),
      .req_noise_fault   (req_noise_fault),
      .req_overrun_fault (req_overrun_fault),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_error    (rsp_read_error),
      .rsp_fifo_empty    (rsp_fifo_empty),
      .rsp_fifo_count    (rsp_fifo_count),
      .rsp_rts_level     (rsp_rts_level),
      .rsp_error_bits    (rsp_error_bits)
   );

endmodule

// File: rtl/core/urxf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module urxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/urxf_ctrl.sv
// Controller for the UART receive FIFO: handshakes and the pop read sequence.
// Depends on urxf_pkg.
`timescale 1ns / 1ps

module urxf_ctrl import urxf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           load_result;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands. A word is taken in ST_IDLE when the result register is
   // empty or is being drained in the same cycle.
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      accept        = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_data = 1'b0;
      load_result   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            accept     = req_valid && req_ready;
            cmd.accept = accept;
            if (accept) begin
               if (status.pop_hit) begin
                  state_in = ST_READ;
               end else begin
                  load_result = 1'b1;
               end
            end
         end
         ST_READ: begin
            // The store data arrives this cycle; the result slot is free.
            cmd.load_data = 1'b1;
            load_result   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/urxf_dp.sv
// Datapath for the UART receive FIFO: byte store, pointers, count, RTS,
// sticky errors, configuration registers and the result register.
// Depends on urxf_pkg and urxf_ram.
`timescale 1ns / 1ps

module urxf_dp import urxf_pkg::*; #(
   parameter int FIFO_DEPTH = 32,
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [1:0]             req_func,
   input  logic                   req_rx_byte_ready,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic                   req_parity_fault,
   input  logic                   req_frame_fault,
   input  logic                   req_noise_fault,
   input  logic                   req_overrun_fault,
   output logic [BYTE_W-1:0]      rsp_read_data,
   output logic                   rsp_read_valid,
   output logic                   rsp_read_error,
   output logic                   rsp_fifo_empty,
   output logic [CNT_W-1:0]       rsp_fifo_count,
   output logic                   rsp_rts_level,
   output logic [ERR_W-1:0]       rsp_error_bits
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // Configuration registers.
   logic                rts_used_ff, rts_used_in;
   logic                parity_en_ff, parity_en_in;
   logic [THRESH_W-1:0] off_thr_ff, off_thr_in;
   logic [THRESH_W-1:0] on_thr_ff, on_thr_in;
   logic [BYTE_W-1:0]   marker_ff, marker_in;

   // FIFO and flow-control state.
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rts_ff, rts_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   logic                rx_en_ff, rx_en_in;

   // Result register.
   logic [BYTE_W-1:0]   res_data_ff;
   logic                res_valid_ff, res_error_ff, res_empty_ff;
   logic [CNT_W-1:0]    res_count_ff;
   logic                res_rts_ff;
   logic [ERR_W-1:0]    res_err_ff;

   // Combinational helpers.
   logic [ERR_W-1:0]    event_err;
   logic                full;
   logic                push_en;
   logic [BYTE_W-1:0]   push_val;
   logic [CNT_W-1:0]    cnt_plus, cnt_minus, cnt_data;
   logic [PTR_W-1:0]    wr_ptr_next, rd_ptr_next;
   logic                res_valid, res_error, res_empty;
   logic [BYTE_W-1:0]   ram_rd_data;

   assign event_err   = {req_overrun_fault, req_noise_fault, req_frame_fault,
                         req_parity_fault & parity_en_ff};
   assign full        = (cnt_ff == CNT_FULL);
   assign cnt_plus    = cnt_ff + CNT_W'(1);
   assign cnt_minus   = cnt_ff - CNT_W'(1);
   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);

   // A pop returns a byte when no error is pending and the FIFO holds one.
   assign status.pop_hit = (req_func == FUNC_POP) && (err_ff == '0) && (cnt_ff != '0);

   // Next state for the accepted word and for configuration writes.
   always_comb begin
      rts_used_in  = rts_used_ff;
      parity_en_in = parity_en_ff;
      off_thr_in   = off_thr_ff;
      on_thr_in    = on_thr_ff;
      marker_in    = marker_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      cnt_in       = cnt_ff;
      rts_in       = rts_ff;
      err_in       = err_ff;
      rx_en_in     = rx_en_ff;
      push_en      = 1'b0;
      push_val     = req_rx_byte;
      cnt_data     = cnt_ff;
      res_valid    = 1'b0;
      res_error    = 1'b0;
      res_empty    = 1'b0;

      if (cmd.accept) begin
         unique case (req_func)
            FUNC_RECEIVE: begin
               if (rx_en_ff) begin
                  err_in = err_ff | event_err;
                  // A clean byte is stored if ready and not full; any error stores the marker instead if not full.
                  if (event_err == '0) begin
                     push_en  = req_rx_byte_ready && !full;
                     push_val = req_rx_byte;
                     cnt_data = push_en ? cnt_plus : cnt_ff;
                  end else begin
                     push_en  = !full;
                     push_val = marker_ff;
                  end
                  // RTS sees the count after the data byte, before any marker.
                  if (req_rx_byte_ready && rts_used_ff && !rts_ff &&
                      (CMP_W'(cnt_data) > CMP_W'(on_thr_ff))) begin
                     rts_in = 1'b1;
                  end
                  if (push_en) begin
                     wr_ptr_in = wr_ptr_next;
                     cnt_in    = cnt_plus;
                  end
               end
            end
            FUNC_POP: begin
               if (err_ff != '0) begin
                  wr_ptr_in = '0;
                  rd_ptr_in = '0;
                  cnt_in    = '0;
                  err_in    = '0;
                  res_error = 1'b1;
               end else if (cnt_ff != '0) begin
                  rd_ptr_in = rd_ptr_next;
                  cnt_in    = cnt_minus;
                  res_valid = 1'b1;
                  if (rts_ff && (CMP_W'(cnt_minus) < CMP_W'(off_thr_ff))) begin
                     rts_in = 1'b0;
                  end
               end else begin
                  res_empty = 1'b1;
               end
            end
            FUNC_ENABLE: begin
               if (rts_used_ff) begin
                  rts_in = 1'b0;
               end
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               cnt_in    = '0;
               err_in    = '0;
               rx_en_in  = 1'b1;
            end
            FUNC_DISABLE: begin
               if (rts_used_ff) begin
                  rts_in = 1'b1;
               end
               rx_en_in = 1'b0;
            end
            default: begin
               rx_en_in = rx_en_ff;
            end
         endcase
      end

      // Configuration writes; writing rts_used reloads the RTS state.
      if (csr_we) begin
         unique case (csr_index)
            CSR_RTS_USED: begin
               rts_used_in = csr_wdata[0];
               rts_in      = csr_wdata[0];
            end
            CSR_PARITY_ENABLED: parity_en_in = csr_wdata[0];
            CSR_RTS_OFF_THRESH: off_thr_in   = csr_wdata[THRESH_W-1:0];
            CSR_RTS_ON_THRESH:  on_thr_in    = csr_wdata[THRESH_W-1:0];
            CSR_ERROR_MARKER:   marker_in    = csr_wdata[BYTE_W-1:0];
            default:            marker_in    = marker_ff;
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rts_used_ff  <= RST_RTS_USED;
         parity_en_ff <= RST_PARITY_ENABLED;
         off_thr_ff   <= RST_RTS_OFF_THRESH;
         on_thr_ff    <= RST_RTS_ON_THRESH;
         marker_ff    <= RST_ERROR_MARKER;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         rts_ff       <= RST_RTS_USED;
         err_ff       <= '0;
         rx_en_ff     <= 1'b0;
      end else begin
         rts_used_ff  <= rts_used_in;
         parity_en_ff <= parity_en_in;
         off_thr_ff   <= off_thr_in;
         on_thr_ff    <= on_thr_in;
         marker_ff    <= marker_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
         rts_ff       <= rts_in;
         err_ff       <= err_in;
         rx_en_ff     <= rx_en_in;
      end
   end

   // Result register. A returned byte passes through the store's read register, then lands here in ST_READ.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_data_ff  <= '0;
         res_valid_ff <= res_valid;
         res_error_ff <= res_error;
         res_empty_ff <= res_empty;
         res_count_ff <= cnt_in;
         res_rts_ff   <= rts_used_ff & rts_in;
         res_err_ff   <= err_in;
      end else if (cmd.load_data) begin
         res_data_ff  <= ram_rd_data;
      end
   end

   // Byte store.
   urxf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept & push_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_val),
      .rd_en   (cmd.accept & status.pop_hit),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_read_data  = res_data_ff;
   assign rsp_read_valid = res_valid_ff;
   assign rsp_read_error = res_error_ff;
   assign rsp_fifo_empty = res_empty_ff;
   assign rsp_fifo_count = res_count_ff;
   assign rsp_rts_level  = res_rts_ff;
   assign rsp_error_bits = res_err_ff;

endmodule
